// File: rtl/core/ksi_pkg.sv
// ----------------------------------------------------------------------------
// ksi_pkg
// Types and constants shared by the keyframe spline interpolator modules.
// ----------------------------------------------------------------------------
package ksi_pkg;

   // Action codes carried by an input item.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_EVAL  = 2'd2;

   // Shared multiplier: A times B, B consumed in 16-bit chunks from the top.
   localparam int MUL_A_W    = 40;
   localparam int CHUNK_W    = 16;
   localparam int MUL_CHUNKS = 3;
   localparam int MUL_B_W    = CHUNK_W * MUL_CHUNKS;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   // Shared restoring divider.
   localparam int DIV_N_W = 70;
   localparam int DIV_D_W = 34;

   // Spline normalization: 2^40/6 rounded up. Multiplying by it and dropping
   // 40 bits gives the exact quotient by six for magnitudes below 2^39.
   localparam logic [MUL_B_W-1:0] SPLINE_RECIP = 48'd183251937963;

   // Full blend weight (pure spline), Q1.15.
   localparam logic [15:0] BLEND_FULL = 16'd32768;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH,
      ST_SCMP,
      ST_FRD,
      ST_FCAP,
      ST_PREP,
      ST_LMUL,
      ST_LDIV,
      ST_UDIV,
      ST_HMUL,
      ST_SDIV,
      ST_BMUL0,
      ST_BMUL1,
      ST_MIX,
      ST_OUT
   } ksi_state_type;

endpackage

// File: rtl/core/ksi_if.sv
// ----------------------------------------------------------------------------
// ksi_if
// Valid/ready channels for the request and response items.
// ----------------------------------------------------------------------------
interface ksi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] sample_time;
   logic signed [31:0] key_value;

   modport source(output valid, action, sample_time, key_value, input ready);
   modport sink(input valid, action, sample_time, key_value, output ready);
endinterface

interface ksi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] curve_value;
   logic               status;

   modport source(output valid, curve_value, status, input ready);
   modport sink(input valid, curve_value, status, output ready);
endinterface

// File: rtl/core/ksi_keys.sv
// ----------------------------------------------------------------------------
// ksi_keys
// Keyframe store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ksi_keys #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_time,
   input  logic signed [31:0] wr_value,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [31:0] rd_time,
   output logic signed [31:0] rd_value
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_ff;

   // Write the time and value of a key together.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_time, wr_value};
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_time  = rd_ff[63:32];
   assign rd_value = rd_ff[31:0];

endmodule

// File: rtl/core/ksi_mul.sv
// ----------------------------------------------------------------------------
// ksi_mul
// Shared unsigned multiplier, one 16-bit chunk of B per cycle.
// ----------------------------------------------------------------------------
module ksi_mul import ksi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] prod,
   output logic               done
);

   logic [MUL_A_W-1:0]         a_ff, a_in;
   logic [MUL_B_W-1:0]         b_ff, b_in;
   logic [MUL_P_W-1:0]         acc_ff, acc_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [MUL_A_W+CHUNK_W-1:0] part;

   // Partial product of A and the top chunk of B.
   assign part = a_ff * b_ff[MUL_B_W-1 -: CHUNK_W];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << CHUNK_W) + MUL_P_W'(part);
         b_in   = b_ff << CHUNK_W;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'(MUL_CHUNKS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

// File: rtl/core/ksi_div.sv
// ----------------------------------------------------------------------------
// ksi_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ksi_div import ksi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic [DIV_N_W-1:0] quotient,
   output logic               done
);

   logic [DIV_N_W-1:0] n_ff, n_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] d_ff, d_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   trial;
   logic [DIV_D_W:0]   diff;
   logic               ge;

   // Bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, n_ff[DIV_N_W-1]};
   assign ge    = trial >= {1'b0, d_ff};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = dividend;
         rem_in  = '0;
         d_in    = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         n_in   = {n_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = n_ff;
   assign done     = done_ff;

endmodule

// File: rtl/core/keyframe_spline_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_spline_interpolator
// Keyframe table with linear and uniform cubic B-spline evaluation.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per action: clear the table, add a key
//   (time, value) in ascending time order, or evaluate at a query time.
//   rsp_chan returns one item per request: the curve value for an evaluate
//   (zero otherwise) and a status bit set when an add found the table full.
//   The APB port holds spline_blend at byte address 0; pready is always high.
// Sequence:
//   Clear, add and unused actions go from idle straight to the output state.
//   An evaluate over N keys makes a search that reads one key at a time from
//   the single read port, four key fetches, up to seven passes through the
//   chunked multiplier (one of them the divide by six) and up to two passes
//   through the 70-step restoring divider. One item is in work at a time;
//   req_chan.ready is high only while the sequencer is idle.
// Reset and stall:
//   Reset empties the table and zeroes spline_blend; key storage itself is
//   not cleared. A finished item waits in the output register while the
//   receiver stalls, and the next request is taken meanwhile; its result is
//   held back until the output register has been emptied.
// ----------------------------------------------------------------------------
module keyframe_spline_interpolator import ksi_pkg::*; #(
   parameter int MAX_KEYS = 64
) (
   input  logic        clock,
   input  logic        reset,
   ksi_req_if.sink     req_chan,
   ksi_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
      logic signed [31:0] r;
      if (x > 42'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -42'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   ksi_state_type state_ff, state_in;

   logic [15:0]         blend_ff, blend_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [1:0]          k_ff, k_in;
   logic signed [31:0]  q_ff, q_in;
   logic signed [31:0]  v_ff [4];
   logic signed [31:0]  v_in [4];
   logic signed [31:0]  t2_ff, t2_in, t3_ff, t3_in;
   logic signed [32:0]  dt_ff, dt_in, dx_ff, dx_in, dv_ff, dv_in;
   logic signed [39:0]  c2_ff, c2_in, c1_ff, c1_in, c0_ff, c0_in;
   logic signed [39:0]  hacc_ff, hacc_in;
   logic [1:0]          hstep_ff, hstep_in;
   logic signed [31:0]  l_ff, l_in;
   logic signed [25:0]  u_ff, u_in;
   logic signed [37:0]  s_ff, s_in;
   logic signed [55:0]  pl_ff, pl_in, pm_ff, pm_in;
   logic signed [31:0]  res_ff, res_in;
   logic                stat_ff, stat_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                req_fire, cfg_write, full, out_free;
   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic signed [31:0]  rd_time, rd_value;

   logic                mul_start, mul_done, mul_state;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  mul_prod;
   logic                div_start, div_done, div_state;
   logic [DIV_N_W-1:0]  div_n;
   logic [DIV_D_W-1:0]  div_d;
   logic [DIV_N_W-1:0]  quo;

   // Fetch index clamped to the table.
   logic signed [CW+1:0] fpos, flast;
   logic [AW-1:0]        faddr;

   // Segment and coefficient terms.
   logic signed [39:0]  e1, e2, e3, e4;
   logic signed [39:0]  c3_w, c2_w, c1_w, c0_w;
   logic signed [32:0]  dt_w, dx_w, dv_w;
   logic [32:0]         dt_mag, dx_mag, dv_mag;
   logic [39:0]         hacc_mag;
   logic [24:0]         u_mag;
   logic [31:0]         l_mag;
   logic [36:0]         s_mag;
   logic [15:0]         w_cap, w_comp;

   // Result assembly for each unit pass.
   logic [40:0]         m_cap;
   logic signed [41:0]  lsum;
   logic [24:0]         ucap;
   logic signed [39:0]  c_sel;
   logic signed [49:0]  hp, hsum;
   logic signed [39:0]  hsat;
   logic signed [55:0]  ps;
   logic [55:0]         mmag;
   logic signed [41:0]  mres;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign cfg_write = psel && penable && pwrite && pready;
   assign full      = count_ff >= CW'(MAX_KEYS);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign mul_state = state_ff inside {ST_LMUL, ST_HMUL, ST_SDIV, ST_BMUL0, ST_BMUL1};
   assign div_state = state_ff inside {ST_LDIV, ST_UDIV};

   // Clamp index i-2+k into [0, count-1].
   assign fpos  = $signed({2'b00, idx_ff}) + $signed({{CW{1'b0}}, k_ff}) - (CW+2)'(2);
   assign flast = $signed({2'b00, count_ff}) - (CW+2)'(1);
   assign faddr = (fpos < 0) ? '0 : (fpos > flast) ? flast[AW-1:0] : fpos[AW-1:0];

   // Spline coefficients, six times scaled.
   assign e1   = {{8{v_ff[0][31]}}, v_ff[0]};
   assign e2   = {{8{v_ff[1][31]}}, v_ff[1]};
   assign e3   = {{8{v_ff[2][31]}}, v_ff[2]};
   assign e4   = {{8{v_ff[3][31]}}, v_ff[3]};
   assign c3_w = e4 - e1 + ((e2 - e3) <<< 1) + (e2 - e3);
   assign c2_w = ((e1 - (e2 <<< 1) + e3) <<< 1) + (e1 - (e2 <<< 1) + e3);
   assign c1_w = ((e3 - e1) <<< 1) + (e3 - e1);
   assign c0_w = e1 + (e2 <<< 2) + e3;
   assign dt_w = {t3_ff[31], t3_ff} - {t2_ff[31], t2_ff};
   assign dx_w = {q_ff[31], q_ff} - {t2_ff[31], t2_ff};
   assign dv_w = {v_ff[2][31], v_ff[2]} - {v_ff[1][31], v_ff[1]};

   // Magnitudes fed to the unsigned units.
   assign dt_mag   = dt_ff[32] ? 33'(-dt_ff) : 33'(dt_ff);
   assign dx_mag   = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign dv_mag   = dv_ff[32] ? 33'(-dv_ff) : 33'(dv_ff);
   assign hacc_mag = hacc_ff[39] ? 40'(-hacc_ff) : 40'(hacc_ff);
   assign u_mag    = u_ff[25] ? 25'(-u_ff) : 25'(u_ff);
   assign l_mag    = l_ff[31] ? 32'(-l_ff) : 32'(l_ff);
   assign s_mag    = s_ff[37] ? 37'(-s_ff) : 37'(s_ff);
   assign w_cap    = (blend_ff > BLEND_FULL) ? BLEND_FULL : blend_ff;
   assign w_comp   = BLEND_FULL - w_cap;

   // Linear result from the capped quotient.
   assign m_cap = (|quo[DIV_N_W-1:40]) ? (41'd1 << 40) : {1'b0, quo[39:0]};
   assign lsum  = {{10{v_ff[1][31]}}, v_ff[1]} +
                  ((dv_ff[32] ^ dx_ff[32] ^ dt_ff[32]) ? -$signed({1'b0, m_cap})
                                                       : $signed({1'b0, m_cap}));
   assign ucap  = (|quo[DIV_N_W-1:24]) ? (25'd1 << 24) : quo[24:0];

   // Horner step: acc*u/65536 toward zero, plus coefficient, saturated.
   assign c_sel = (hstep_ff == 2'd0) ? c2_ff : (hstep_ff == 2'd1) ? c1_ff : c0_ff;
   assign hp    = (hacc_ff[39] ^ u_ff[25]) ? -$signed({3'b000, mul_prod[62:16]})
                                           : $signed({3'b000, mul_prod[62:16]});
   assign hsum  = hp + {{10{c_sel[39]}}, c_sel};
   assign hsat  = (hsum > (50'sd1 <<< 38)) ? (40'sd1 <<< 38) :
                  (hsum < -(50'sd1 <<< 38)) ? -(40'sd1 <<< 38) : hsum[39:0];

   // Blend terms and final scaling toward zero.
   assign ps   = s_ff[37] ? -$signed({5'b00000, mul_prod[50:0]})
                          : $signed({5'b00000, mul_prod[50:0]});
   assign mmag = pm_ff[55] ? 56'(-pm_ff) : 56'(pm_ff);
   assign mres = pm_ff[55] ? -$signed({1'b0, mmag[55:15]}) : $signed({1'b0, mmag[55:15]});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action == ACT_EVAL && count_ff != '0) begin
                  state_in = ST_SRCH;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SRCH:  state_in = (idx_ff >= count_ff) ? ST_FRD : ST_SCMP;
         ST_SCMP:  state_in = (rd_time > q_ff) ? ST_FRD : ST_SRCH;
         ST_FRD:   state_in = ST_FCAP;
         ST_FCAP:  state_in = (k_ff == 2'd3) ? ST_PREP : ST_FRD;
         ST_PREP:  state_in = (dt_w == '0) ? ST_HMUL : ST_LMUL;
         ST_LMUL:  if (mul_done) state_in = ST_LDIV;
         ST_LDIV:  if (div_done) state_in = ST_UDIV;
         ST_UDIV:  if (div_done) state_in = ST_HMUL;
         ST_HMUL:  if (mul_done && hstep_ff == 2'd2) state_in = ST_SDIV;
         ST_SDIV:  if (mul_done) state_in = ST_BMUL0;
         ST_BMUL0: if (mul_done) state_in = ST_BMUL1;
         ST_BMUL1: if (mul_done) state_in = ST_MIX;
         ST_MIX:   state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Unit launches, operand selection and table access.
   always_comb begin
      mul_start = mul_state && !pend_ff;
      div_start = div_state && !pend_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_n     = '0;
      div_d     = '0;
      rd_addr   = faddr;
      wr_en     = req_fire && req_chan.action == ACT_ADD && !full;
      case (state_ff)
         ST_SRCH: begin
            rd_addr = idx_ff[AW-1:0];
         end
         ST_LMUL: begin
            mul_a = MUL_A_W'(dv_mag);
            mul_b = MUL_B_W'(dx_mag);
         end
         ST_LDIV: begin
            div_n = DIV_N_W'(mul_prod[65:0]);
            div_d = DIV_D_W'(dt_mag);
         end
         ST_UDIV: begin
            div_n = DIV_N_W'({dx_mag, 16'h0000});
            div_d = DIV_D_W'(dt_mag);
         end
         ST_HMUL: begin
            mul_a = hacc_mag;
            mul_b = MUL_B_W'(u_mag);
         end
         ST_SDIV: begin
            mul_a = hacc_mag;
            mul_b = SPLINE_RECIP;
         end
         ST_BMUL0: begin
            mul_a = MUL_A_W'(l_mag);
            mul_b = MUL_B_W'(w_comp);
         end
         ST_BMUL1: begin
            mul_a = MUL_A_W'(s_mag);
            mul_b = MUL_B_W'(w_cap);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      blend_in      = blend_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      q_in          = q_ff;
      v_in          = v_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      dt_in         = dt_ff;
      dx_in         = dx_ff;
      dv_in         = dv_ff;
      c2_in         = c2_ff;
      c1_in         = c1_ff;
      c0_in         = c0_ff;
      hacc_in       = hacc_ff;
      hstep_in      = hstep_ff;
      l_in          = l_ff;
      u_in          = u_ff;
      s_in          = s_ff;
      pl_in         = pl_ff;
      pm_in         = pm_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      pend_in       = pend_ff;

      if (cfg_write && !paddr[2]) begin
         blend_in = pwdata[15:0];
      end

      if (mul_done || div_done) begin
         pend_in = 1'b0;
      end else if (mul_start || div_start) begin
         pend_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_in  = '0;
               stat_in = 1'b0;
               q_in    = req_chan.sample_time;
               idx_in  = CW'(1);
               k_in    = '0;
               if (req_chan.action == ACT_CLEAR) begin
                  count_in = '0;
               end else if (req_chan.action == ACT_ADD) begin
                  if (full) begin
                     stat_in = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
         end
         ST_SCMP: begin
            if (!(rd_time > q_ff)) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_FCAP: begin
            v_in[k_ff] = rd_value;
            if (k_ff == 2'd1) t2_in = rd_time;
            if (k_ff == 2'd2) t3_in = rd_time;
            k_in = k_ff + 2'd1;
         end
         ST_PREP: begin
            dt_in    = dt_w;
            dx_in    = dx_w;
            dv_in    = dv_w;
            c2_in    = c2_w;
            c1_in    = c1_w;
            c0_in    = c0_w;
            hacc_in  = c3_w;
            hstep_in = '0;
            if (dt_w == '0) begin
               l_in = v_ff[1];
               u_in = '0;
            end
         end
         ST_LDIV: begin
            if (div_done) l_in = sat32(lsum);
         end
         ST_UDIV: begin
            if (div_done) begin
               u_in = (dx_ff[32] ^ dt_ff[32]) ? -$signed({1'b0, ucap}) : $signed({1'b0, ucap});
            end
         end
         ST_HMUL: begin
            if (mul_done) begin
               hacc_in  = hsat;
               hstep_in = hstep_ff + 2'd1;
            end
         end
         ST_SDIV: begin
            if (mul_done) begin
               s_in = hacc_ff[39] ? -$signed({1'b0, mul_prod[76:40]})
                                  : $signed({1'b0, mul_prod[76:40]});
            end
         end
         ST_BMUL0: begin
            if (mul_done) begin
               pl_in = l_ff[31] ? -$signed({8'h00, mul_prod[47:0]})
                                : $signed({8'h00, mul_prod[47:0]});
            end
         end
         ST_BMUL1: begin
            if (mul_done) pm_in = pl_ff + ps;
         end
         ST_MIX: begin
            res_in = sat32(mres);
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = stat_ff;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      q_ff          <= q_in;
      v_ff          <= v_in;
      t2_ff         <= t2_in;
      t3_ff         <= t3_in;
      dt_ff         <= dt_in;
      dx_ff         <= dx_in;
      dv_ff         <= dv_in;
      c2_ff         <= c2_in;
      c1_ff         <= c1_in;
      c0_ff         <= c0_in;
      hacc_ff       <= hacc_in;
      hstep_ff      <= hstep_in;
      l_ff          <= l_in;
      u_ff          <= u_in;
      s_ff          <= s_in;
      pl_ff         <= pl_in;
      pm_ff         <= pm_in;
      res_ff        <= res_in;
      stat_ff       <= stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         blend_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blend_ff     <= blend_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Key table.
   ksi_keys #(
      .DEPTH(MAX_KEYS),
      .AW(AW)
   ) u_keys (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_time(req_chan.sample_time),
      .wr_value(req_chan.key_value),
      .rd_addr(rd_addr),
      .rd_time(rd_time),
      .rd_value(rd_value)
   );

   // Shared multiplier.
   ksi_mul u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .a(mul_a),
      .b(mul_b),
      .prod(mul_prod),
      .done(mul_done)
   );

   // Shared divider.
   ksi_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_n),
      .divisor(div_d),
      .quotient(quo),
      .done(div_done)
   );

   // Channel and register port outputs.
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.curve_value = rsp_value_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign prdata               = paddr[2] ? 32'h0 : {16'h0000, blend_ff};
   assign pready               = 1'b1;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS))
      else $error("key count exceeds table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted item did not start the sequencer");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result item appeared outside the output state");

   a_unit_excl: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");
`endif

endmodule
